// ----- src/mlc_pkg.sv -----
// shared types, constants and helper functions of the mouse-look camera block
`default_nettype none
package mlc_pkg;

    // configuration defaults
    localparam int POS_BITS_DEF  = 13;
    localparam int FRAC_BITS_DEF = 16;
    localparam int SPEED_RST     = 5120;
    localparam int SENS_RST      = 328;
    localparam int PLIM_RST      = 101797;
    localparam int MOUSE_X_RST   = 980;
    localparam int MOUSE_Y_RST   = 540;

    // angle constants, Q16 radians
    localparam int TWO_PI_Q  = 411775;
    localparam int PI_Q      = 205887;
    localparam int HALF_PI_Q = 102944;
    localparam int PITCH_MAX = 102943;

    // cordic start value, Q30
    localparam int CORDIC_GAIN = 652032874;

    // datapath widths
    localparam int MUL_W    = 33;
    localparam int CORDIC_W = 34;
    localparam int ANG_W    = 20;

    // request kinds carried in tuser
    typedef enum logic [1:0] {
        REQ_MOUSE   = 2'd0,
        REQ_TICK    = 2'd1,
        REQ_SET_EYE = 2'd2,
        REQ_SET_TGT = 2'd3
    } t_req;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SPEED = 2'd0,
        CFG_SENS  = 2'd1,
        CFG_PLIM  = 2'd2
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_MM_MUL0,
        S_MM_MUL1,
        S_MM_PV,
        S_MM_MOD,
        S_MM_YFIX,
        S_CS,
        S_CR,
        S_CE,
        S_LK0,
        S_LK1,
        S_LK2,
        S_TK0,
        S_TK1,
        S_NORM,
        S_SQ0,
        S_SQ1,
        S_SQ2,
        S_SQ3,
        S_SQRT,
        S_DVI,
        S_DV,
        S_MV0,
        S_MV1,
        S_DONE
    } t_state;

    // operand pair for the shared multiplier
    typedef struct packed {
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } t_mul_req;

    // arctangent of 2^-i, Q16 radians
    function automatic logic signed [ANG_W-1:0] atan_q16(input logic [3:0] i);
        logic signed [ANG_W-1:0] v;
        case (i)
            4'd0:    v = 20'sd51472;
            4'd1:    v = 20'sd30386;
            4'd2:    v = 20'sd16055;
            4'd3:    v = 20'sd8150;
            4'd4:    v = 20'sd4091;
            4'd5:    v = 20'sd2047;
            4'd6:    v = 20'sd1024;
            4'd7:    v = 20'sd512;
            4'd8:    v = 20'sd256;
            4'd9:    v = 20'sd128;
            4'd10:   v = 20'sd64;
            4'd11:   v = 20'sd32;
            4'd12:   v = 20'sd16;
            4'd13:   v = 20'sd8;
            4'd14:   v = 20'sd4;
            default: v = 20'sd2;
        endcase
        return v;
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/mlc_mul.sv -----
// shared signed multiplier with registered product
`default_nettype none
module mlc_mul
    import mlc_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire t_mul_req                   i_req,
    output logic signed [2*MUL_W-1:0]       o_prod
);

    logic signed [2*MUL_W-1:0] r_prod;

    // one product per cycle, ready in the next
    always_ff @(posedge i_clk) begin
        r_prod <= i_req.a * i_req.b;
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

// ----- src/mouse_look_camera_update_top.sv -----
// top level of the mouse-look camera: sequencer, datapath and stream ports
//
//  channel   dir  handshake                        payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata inputs, tuser req_type
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata eye/target, tuser moved
//  cfg       in   i_cfg_we                         i_cfg_addr, i_cfg_wdata
//
//  set items go straight to the done state; mouse moves run the two multiplies,
//  the pitch clamp, the yaw modulo steps and two 16-step cordic passes; ticks
//  run the normalize shifts, the 32-step root and three 31-step divides.
//  one item at a time; input ready only while the sequencer is idle.
//  a result waits in the output register; a stalled output holds the sequencer.
//  synchronous active-low reset, no clearing pass.
`default_nettype none
module mouse_look_camera_update_top
    import mlc_pkg::*;
#(
    parameter int POS_BITS  = POS_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // input stream
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // mouse_x, mouse_y, key_forward, key_back, tick_length, vec_x, vec_y, vec_z
    input  wire logic [143:0]  i_s_axis_tdata,
    // req_type
    input  wire logic [1:0]    i_s_axis_tuser,
    // result stream
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z
    output logic [191:0]       o_m_axis_tdata,
    // moved
    output logic [0:0]         o_m_axis_tuser,
    // configuration writes
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_addr,
    input  wire logic [16:0]   i_cfg_wdata
);

    localparam int VW = POS_BITS + 20;
    localparam int PW = 2 * MUL_W;

    t_state r_state, n_state;
    logic [5:0] r_cnt;
    logic       r_pass;
    logic [1:0] r_k;

    logic [15:0] r_speed, r_sens;
    logic [16:0] r_plim;

    logic [POS_BITS-1:0]  r_last_x, r_last_y;
    logic signed [POS_BITS:0] r_dx, r_dy;
    logic [19:0]          r_yaw;
    logic signed [19:0]   r_pitch;
    logic signed [31:0]   r_eye [3];
    logic signed [31:0]   r_tgt [3];
    logic                 r_fwd, r_bck;
    logic [15:0]          r_tlen;

    logic [VW-1:0] r_acc;
    logic          r_vneg;

    logic signed [CORDIC_W-1:0] r_x, r_y, r_sy, r_cy, r_sp, r_cp;
    logic signed [ANG_W-1:0]    r_z;
    logic                       r_flip;

    logic [31:0] r_amt;
    logic [32:0] r_mag [3];
    logic        r_neg [3];
    logic [32:0] r_m;
    logic [63:0] r_sum, r_root, r_bit;
    logic [32:0] r_rem;
    logic [30:0] r_q;
    logic        r_moved;

    logic         r_out_valid;
    logic [191:0] r_out_data;
    logic         r_out_moved;

    t_mul_req             w_mul;
    logic signed [PW-1:0] w_prod;

    mlc_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mul),
        .o_prod (w_prod)
    );

    // position rounding from Q30
    function automatic logic signed [33:0] q30_pos(input logic signed [35:0] v);
        logic signed [35:0] t;
        t = v + (36'sd1 <<< (29 - FRAC_BITS));
        return 34'(t >>> (30 - FRAC_BITS));
    endfunction

    // input field decode
    logic                 w_accept;
    t_req                 w_req;
    logic [15:0]          w_mx_full, w_my_full;
    logic [POS_BITS-1:0]  w_mx, w_my;
    assign w_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_req     = t_req'(i_s_axis_tuser);
    assign w_mx_full = {3'b000, i_s_axis_tdata[12:0]};
    assign w_my_full = {3'b000, i_s_axis_tdata[25:13]};
    assign w_mx      = w_mx_full[POS_BITS-1:0];
    assign w_my      = w_my_full[POS_BITS-1:0];

    // yaw sum, pitch clamp and modulo step
    logic signed [VW-1:0] w_yaw_sum, w_pv, w_lim_s;
    logic [VW-1:0]        w_yaw_abs, w_mod_sub;
    logic [16:0]          w_lim;
    logic [5:0]           w_sh;
    logic [19:0]          w_yv;
    logic signed [19:0]   w_ya, w_ang, w_ang_f;
    logic                 w_fold;
    assign w_yaw_sum = $signed({{(VW-20){1'b0}}, r_yaw}) + $signed(w_prod[VW-1:0]);
    assign w_yaw_abs = w_yaw_sum[VW-1] ? VW'(-w_yaw_sum) : VW'(w_yaw_sum);
    assign w_pv      = VW'(r_pitch) + $signed(w_prod[VW-1:0]);
    assign w_lim     = (r_plim > 17'(PITCH_MAX)) ? 17'(PITCH_MAX) : r_plim;
    assign w_lim_s   = $signed({{(VW-17){1'b0}}, w_lim});
    assign w_sh      = 6'(POS_BITS - 1) - r_cnt;
    assign w_mod_sub = VW'(TWO_PI_Q) << w_sh;
    assign w_yv      = (r_vneg && (r_acc != '0)) ? 20'(VW'(TWO_PI_Q) - r_acc) : r_acc[19:0];
    assign w_ya      = (r_yaw > 20'(PI_Q)) ? $signed(r_yaw) - 20'sd411775 : $signed(r_yaw);

    // cordic argument fold into the half-pi range
    always_comb begin
        w_ang  = r_pass ? r_pitch : w_ya;
        w_fold = 1'b0;
        w_ang_f = w_ang;
        if (w_ang > 20'sd102944) begin
            w_ang_f = w_ang - 20'sd205887;
            w_fold  = 1'b1;
        end else if (w_ang < -20'sd102944) begin
            w_ang_f = w_ang + 20'sd205887;
            w_fold  = 1'b1;
        end
    end

    // cordic micro-rotation terms
    logic signed [CORDIC_W-1:0] w_xs, w_ys;
    logic signed [ANG_W-1:0]    w_at;
    assign w_xs = r_x >>> r_cnt[3:0];
    assign w_ys = r_y >>> r_cnt[3:0];
    assign w_at = atan_q16(r_cnt[3:0]);

    // look vector to target
    logic signed [33:0] w_look_pos, w_negsp_pos;
    assign w_look_pos  = q30_pos($signed(w_prod[PW-1:30]));
    assign w_negsp_pos = q30_pos(-36'(r_sp));

    // tick direction and largest magnitude
    logic signed [32:0] w_d [3];
    logic [32:0]        w_dm [3];
    logic [32:0]        w_max;
    logic [31:0]        w_amt;
    logic               w_still;
    assign w_amt   = w_prod[31:0];
    assign w_still = (r_fwd == r_bck) || (w_amt == 32'd0);
    always_comb begin
        w_max = '0;
        for (int k = 0; k < 3; k++) begin
            w_d[k]  = 33'(r_tgt[k]) - 33'(r_eye[k]);
            w_dm[k] = w_d[k][32] ? 33'(-w_d[k]) : 33'(w_d[k]);
            if (w_dm[k] > w_max) begin
                w_max = w_dm[k];
            end
        end
    end

    // root step, divide step and move amount
    logic [63:0]        w_rb, w_mvsum;
    logic [32:0]        w_len, w_mv;
    logic signed [33:0] w_sv, w_eye_n, w_tgt_n;
    assign w_rb    = r_root + r_bit;
    assign w_len   = r_root[32:0];
    assign w_mvsum = w_prod[63:0] + (64'd1 << (53 - FRAC_BITS));
    assign w_mv    = 33'(w_mvsum >> (54 - FRAC_BITS));
    assign w_sv    = (r_neg[r_k] ^ r_bck) ? -$signed({1'b0, w_mv}) : $signed({1'b0, w_mv});
    assign w_eye_n = 34'(r_eye[r_k]) + w_sv;
    assign w_tgt_n = 34'(r_tgt[r_k]) + w_sv;

    logic w_out_free;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_req)
                        REQ_MOUSE: n_state = S_MM_MUL0;
                        REQ_TICK:  n_state = S_TK0;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_MM_MUL0: n_state = S_MM_MUL1;
            S_MM_MUL1: n_state = S_MM_PV;
            S_MM_PV:   n_state = S_MM_MOD;
            S_MM_MOD: begin
                if (r_cnt == 6'(POS_BITS - 1)) n_state = S_MM_YFIX;
            end
            S_MM_YFIX: n_state = S_CS;
            S_CS:      n_state = S_CR;
            S_CR: begin
                if (r_cnt == 6'd15) n_state = S_CE;
            end
            S_CE:      n_state = r_pass ? S_LK0 : S_CS;
            S_LK0:     n_state = S_LK1;
            S_LK1:     n_state = S_LK2;
            S_LK2:     n_state = S_DONE;
            S_TK0:     n_state = S_TK1;
            S_TK1:     n_state = (w_still || (w_max == '0)) ? S_DONE : S_NORM;
            S_NORM: begin
                if (r_m < 33'h040000000 && r_m >= 33'h020000000) n_state = S_SQ0;
            end
            S_SQ0:     n_state = S_SQ1;
            S_SQ1:     n_state = S_SQ2;
            S_SQ2:     n_state = S_SQ3;
            S_SQ3:     n_state = S_SQRT;
            S_SQRT: begin
                if (r_cnt == 6'd31) n_state = S_DVI;
            end
            S_DVI:     n_state = S_DV;
            S_DV: begin
                if (r_cnt == 6'd30) n_state = S_MV0;
            end
            S_MV0:     n_state = S_MV1;
            S_MV1:     n_state = (r_k == 2'd2) ? S_DONE : S_DVI;
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: ready and multiplier operands
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_mul.a = '0;
        w_mul.b = '0;
        case (r_state)
            S_IDLE:    o_s_axis_tready = 1'b1;
            S_MM_MUL0: begin
                w_mul.a = MUL_W'(r_dx);
                w_mul.b = $signed({{(MUL_W-16){1'b0}}, r_sens});
            end
            S_MM_MUL1: begin
                w_mul.a = MUL_W'(r_dy);
                w_mul.b = $signed({{(MUL_W-16){1'b0}}, r_sens});
            end
            S_LK0: begin
                w_mul.a = r_cp[MUL_W-1:0];
                w_mul.b = r_sy[MUL_W-1:0];
            end
            S_LK1: begin
                w_mul.a = r_cp[MUL_W-1:0];
                w_mul.b = r_cy[MUL_W-1:0];
            end
            S_TK0: begin
                w_mul.a = $signed({{(MUL_W-16){1'b0}}, r_speed});
                w_mul.b = $signed({{(MUL_W-16){1'b0}}, r_tlen});
            end
            S_SQ0: begin
                w_mul.a = $signed(r_mag[0]);
                w_mul.b = $signed(r_mag[0]);
            end
            S_SQ1: begin
                w_mul.a = $signed(r_mag[1]);
                w_mul.b = $signed(r_mag[1]);
            end
            S_SQ2: begin
                w_mul.a = $signed(r_mag[2]);
                w_mul.b = $signed(r_mag[2]);
            end
            S_MV0: begin
                w_mul.a = $signed({2'b00, r_q});
                w_mul.b = $signed({1'b0, r_amt});
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    // control registers and camera state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pass      <= 1'b0;
            r_k         <= '0;
            r_speed     <= 16'(SPEED_RST);
            r_sens      <= 16'(SENS_RST);
            r_plim      <= 17'(PLIM_RST);
            r_last_x    <= POS_BITS'(MOUSE_X_RST);
            r_last_y    <= POS_BITS'(MOUSE_Y_RST);
            r_yaw       <= '0;
            r_pitch     <= '0;
            r_out_valid <= 1'b0;
            r_moved     <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_eye[k] <= '0;
                r_tgt[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state) ? 6'd0 : r_cnt + 6'd1;

            // configuration writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_SPEED: r_speed <= i_cfg_wdata[15:0];
                    CFG_SENS:  r_sens  <= i_cfg_wdata[15:0];
                    CFG_PLIM:  r_plim  <= i_cfg_wdata;
                    default:   r_speed <= r_speed;
                endcase
            end

            // result transfer
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_moved <= 1'b0;
                        case (w_req)
                            REQ_MOUSE: begin
                                r_dx     <= $signed({1'b0, w_mx}) - $signed({1'b0, r_last_x});
                                r_dy     <= $signed({1'b0, w_my}) - $signed({1'b0, r_last_y});
                                r_last_x <= w_mx;
                                r_last_y <= w_my;
                            end
                            REQ_SET_EYE: begin
                                r_eye[0] <= i_s_axis_tdata[75:44];
                                r_eye[1] <= i_s_axis_tdata[107:76];
                                r_eye[2] <= i_s_axis_tdata[139:108];
                            end
                            REQ_SET_TGT: begin
                                r_tgt[0] <= i_s_axis_tdata[75:44];
                                r_tgt[1] <= i_s_axis_tdata[107:76];
                                r_tgt[2] <= i_s_axis_tdata[139:108];
                            end
                            default: begin
                                r_fwd  <= i_s_axis_tdata[26];
                                r_bck  <= i_s_axis_tdata[27];
                                r_tlen <= i_s_axis_tdata[43:28];
                            end
                        endcase
                    end
                end
                S_MM_MUL1: begin
                    r_acc  <= w_yaw_abs;
                    r_vneg <= w_yaw_sum[VW-1];
                end
                S_MM_PV: begin
                    if (w_pv > w_lim_s) begin
                        r_pitch <= 20'(w_lim_s);
                    end else if (w_pv < -w_lim_s) begin
                        r_pitch <= 20'(-w_lim_s);
                    end else begin
                        r_pitch <= 20'(w_pv);
                    end
                end
                S_MM_MOD: begin
                    if (r_acc >= w_mod_sub) r_acc <= r_acc - w_mod_sub;
                end
                S_MM_YFIX: begin
                    r_yaw  <= w_yv;
                    r_pass <= 1'b0;
                end
                S_CS: begin
                    r_x    <= CORDIC_W'(CORDIC_GAIN);
                    r_y    <= '0;
                    r_z    <= w_ang_f;
                    r_flip <= w_fold;
                end
                S_CR: begin
                    if (r_z >= 0) begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                        r_z <= r_z - w_at;
                    end else begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                        r_z <= r_z + w_at;
                    end
                end
                S_CE: begin
                    if (r_pass) begin
                        r_sp <= r_flip ? -r_y : r_y;
                        r_cp <= r_flip ? -r_x : r_x;
                    end else begin
                        r_sy <= r_flip ? -r_y : r_y;
                        r_cy <= r_flip ? -r_x : r_x;
                    end
                    r_pass <= 1'b1;
                end
                S_LK1: begin
                    r_tgt[0] <= sat32(34'(r_eye[0]) + w_look_pos);
                end
                S_LK2: begin
                    r_tgt[1] <= sat32(34'(r_eye[1]) + w_negsp_pos);
                    r_tgt[2] <= sat32(34'(r_eye[2]) + w_look_pos);
                end
                S_TK1: begin
                    r_amt   <= w_amt;
                    r_moved <= !w_still;
                    r_m     <= w_max;
                    for (int k = 0; k < 3; k++) begin
                        r_mag[k] <= w_dm[k];
                        r_neg[k] <= w_d[k][32];
                    end
                end
                S_NORM: begin
                    if (r_m >= 33'h040000000) begin
                        r_m <= r_m >> 1;
                        for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] >> 1;
                    end else if (r_m < 33'h020000000) begin
                        r_m <= r_m << 1;
                        for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] << 1;
                    end
                end
                S_SQ1: r_sum <= 64'(w_prod[61:0]);
                S_SQ2: r_sum <= r_sum + 64'(w_prod[61:0]);
                S_SQ3: begin
                    r_sum  <= r_sum + 64'(w_prod[61:0]);
                    r_root <= '0;
                    r_bit  <= 64'h4000_0000_0000_0000;
                    r_k    <= '0;
                end
                S_SQRT: begin
                    if (r_sum >= w_rb) begin
                        r_sum  <= r_sum - w_rb;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
                S_DVI: begin
                    r_rem <= r_mag[r_k];
                    r_q   <= '0;
                end
                S_DV: begin
                    if (r_rem >= w_len) begin
                        r_rem <= (r_rem - w_len) << 1;
                        r_q   <= {r_q[29:0], 1'b1};
                    end else begin
                        r_rem <= r_rem << 1;
                        r_q   <= {r_q[29:0], 1'b0};
                    end
                end
                S_MV1: begin
                    r_eye[r_k] <= sat32(w_eye_n);
                    r_tgt[r_k] <= sat32(w_tgt_n);
                    r_k        <= r_k + 2'd1;
                end
                default: begin
                    r_pass <= r_pass;
                end
            endcase
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_data  <= {r_tgt[2], r_tgt[1], r_tgt[0], r_eye[2], r_eye[1], r_eye[0]};
            r_out_moved <= r_moved;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_moved;

`ifndef ASSERT_OFF
    // right after an accepted item the input is closed
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_axis_tready)
        else $error("input ready right after a transfer");

    // yaw stays wrapped
    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_yaw < 20'(TWO_PI_Q))
        else $error("yaw outside its wrap range");

    // pitch stays inside the hard limit
    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pitch <= 20'sd102943) && (r_pitch >= -20'sd102943))
        else $error("pitch beyond limit");

    // a finished item shows a result and reopens the input
    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (o_m_axis_tvalid && o_s_axis_tready))
        else $error("finished item did not reach the output register");
`endif

endmodule
`default_nettype wire
